/* rtl/core/point_segment_distance_macros.svh */
// Assertion macros for the point-to-segment distance pipeline.
`ifndef POINT_SEGMENT_DISTANCE_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_MACROS_SVH

// Same-cycle implication, clocked on clock, quiet during reset
`define PSD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("psd assertion failed");

// Next-cycle implication
`define PSD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("psd assertion failed");

`endif

/* rtl/core/psd_pkg.sv */
// Types and width constants for the point-to-segment distance pipeline.
package psd_pkg;

   localparam int COORD_W    = 32;
   localparam int DIFF_W     = 33;   // coordinate difference
   localparam int PROD_W     = 66;   // product of two differences
   localparam int SQ_W       = 66;   // sum of three squares
   localparam int DOT_W      = 68;   // signed dot product
   localparam int HI_W       = 34;   // upper part of e
   localparam int LO_W       = 32;   // lower part of e
   localparam int ESQ_W      = 132;  // e squared
   localparam int DIV_STEPS  = 66;   // quotient bits
   localparam int DIST_W     = 33;
   localparam int SQRT_STEPS = 33;   // root bits

   typedef enum logic [1:0] {
      REGION_START    = 2'd0,
      REGION_END      = 2'd1,
      REGION_INTERIOR = 2'd2
   } region_type;

endpackage

/* rtl/core/point_segment_distance.sv */
// Throughput: one item per cycle while the output is not stalled; the 66-stage quotient
// pipeline and the 33-stage root pipeline each retire one bit per stage, so a new item enters every cycle.
// A stalled output freezes every stage together; nothing is dropped or repeated.
// Reset (synchronous, active high) clears every stage's valid bit; data is not reset.
`include "point_segment_distance_macros.svh"

module point_segment_distance
   import psd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [COORD_W-1:0]  req_start_x,
   input  logic signed [COORD_W-1:0]  req_start_y,
   input  logic signed [COORD_W-1:0]  req_start_z,
   input  logic signed [COORD_W-1:0]  req_end_x,
   input  logic signed [COORD_W-1:0]  req_end_y,
   input  logic signed [COORD_W-1:0]  req_end_z,
   input  logic signed [COORD_W-1:0]  req_query_x,
   input  logic signed [COORD_W-1:0]  req_query_y,
   input  logic signed [COORD_W-1:0]  req_query_z,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic        [DIST_W-1:0]   rsp_distance,
   output logic        [1:0]          rsp_nearest_region
);

   logic adv;
   logic stall;

   // whole pipeline moves when the output register is free or being taken
   assign adv       = ~rsp_valid | rsp_ready;
   assign stall     = ~adv;
   assign req_ready = adv;

   // ---------------- stage 1: differences
   logic                     v1_ff;
   logic signed [DIFF_W-1:0] ab_ff [3];
   logic signed [DIFF_W-1:0] ac_ff [3];
   logic signed [DIFF_W-1:0] bc_ff [3];
   logic signed [DIFF_W-1:0] ab_in [3];
   logic signed [DIFF_W-1:0] ac_in [3];
   logic signed [DIFF_W-1:0] bc_in [3];

   always_comb begin
      ab_in[0] = DIFF_W'(req_end_x)   - DIFF_W'(req_start_x);
      ab_in[1] = DIFF_W'(req_end_y)   - DIFF_W'(req_start_y);
      ab_in[2] = DIFF_W'(req_end_z)   - DIFF_W'(req_start_z);
      ac_in[0] = DIFF_W'(req_query_x) - DIFF_W'(req_start_x);
      ac_in[1] = DIFF_W'(req_query_y) - DIFF_W'(req_start_y);
      ac_in[2] = DIFF_W'(req_query_z) - DIFF_W'(req_start_z);
      bc_in[0] = DIFF_W'(req_query_x) - DIFF_W'(req_end_x);
      bc_in[1] = DIFF_W'(req_query_y) - DIFF_W'(req_end_y);
      bc_in[2] = DIFF_W'(req_query_z) - DIFF_W'(req_end_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
      if (adv) begin
         ab_ff <= ab_in;
         ac_ff <= ac_in;
         bc_ff <= bc_in;
      end
   end

   // ---------------- stage 2: twelve products
   logic                     v2_ff;
   logic signed [PROD_W-1:0] pe_ff [3];   // ac*ab
   logic signed [PROD_W-1:0] pf_ff [3];   // ab*ab
   logic signed [PROD_W-1:0] pa_ff [3];   // ac*ac
   logic signed [PROD_W-1:0] pb_ff [3];   // bc*bc

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            pe_ff[i] <= ac_ff[i] * ab_ff[i];
            pf_ff[i] <= ab_ff[i] * ab_ff[i];
            pa_ff[i] <= ac_ff[i] * ac_ff[i];
            pb_ff[i] <= bc_ff[i] * bc_ff[i];
         end
      end
   end

   // ---------------- stage 3: dot products
   logic                    v3_ff;
   logic signed [DOT_W-1:0] e3_ff;
   logic        [SQ_W-1:0]  f3_ff;
   logic        [SQ_W-1:0]  acac3_ff;
   logic        [SQ_W-1:0]  bcbc3_ff;

   // squares are nonnegative and below 2^65
   function automatic logic [SQ_W-1:0] sq3(input logic signed [PROD_W-1:0] p [3]);
      sq3 = SQ_W'(p[0][PROD_W-2:0]) + SQ_W'(p[1][PROD_W-2:0]) + SQ_W'(p[2][PROD_W-2:0]);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         e3_ff    <= DOT_W'(pe_ff[0]) + DOT_W'(pe_ff[1]) + DOT_W'(pe_ff[2]);
         f3_ff    <= sq3(pf_ff);
         acac3_ff <= sq3(pa_ff);
         bcbc3_ff <= sq3(pb_ff);
      end
   end

   // ---------------- stage 4: region decision
   logic              v4_ff;
   region_type        region4_ff, region4_in;
   logic [SQ_W-1:0]   e4_ff;
   logic [SQ_W-1:0]   f4_ff;
   logic [SQ_W-1:0]   acac4_ff;
   logic [SQ_W-1:0]   direct4_ff, direct4_in;

   always_comb begin
      if (e3_ff[DOT_W-1] || (e3_ff == '0)) begin
         region4_in = REGION_START;
         direct4_in = acac3_ff;
      end else if (e3_ff >= DOT_W'(f3_ff)) begin
         region4_in = REGION_END;
         direct4_in = bcbc3_ff;
      end else begin
         region4_in = REGION_INTERIOR;
         direct4_in = acac3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv) begin
         region4_ff <= region4_in;
         direct4_ff <= direct4_in;
         e4_ff      <= e3_ff[SQ_W-1:0];   // exact whenever 0 < e < f
         f4_ff      <= f3_ff;
         acac4_ff   <= acac3_ff;
      end
   end

   // ---------------- stage 5: partial products of e squared
   logic                     v5_ff;
   region_type               region5_ff;
   logic [SQ_W-1:0]          f5_ff, acac5_ff, direct5_ff;
   logic [2*HI_W-1:0]        hh5_ff;
   logic [HI_W+LO_W-1:0]     hl5_ff;
   logic [2*LO_W-1:0]        ll5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
      if (adv) begin
         hh5_ff     <= e4_ff[SQ_W-1:LO_W] * e4_ff[SQ_W-1:LO_W];
         hl5_ff     <= e4_ff[SQ_W-1:LO_W] * e4_ff[LO_W-1:0];
         ll5_ff     <= e4_ff[LO_W-1:0] * e4_ff[LO_W-1:0];
         region5_ff <= region4_ff;
         f5_ff      <= f4_ff;
         acac5_ff   <= acac4_ff;
         direct5_ff <= direct4_ff;
      end
   end

   // ---------------- stage 6 and quotient pipeline: floor(e*e / f)
   // Entry 0 is loaded from the partial products; entry k+1 is one quotient bit on.
   logic              div_v_ff      [DIV_STEPS+1];
   logic [SQ_W-1:0]   div_rem_ff    [DIV_STEPS+1];
   logic [SQ_W-1:0]   div_num_ff    [DIV_STEPS+1];
   logic [SQ_W-1:0]   div_quo_ff    [DIV_STEPS+1];
   logic [SQ_W-1:0]   div_f_ff      [DIV_STEPS+1];
   logic [SQ_W-1:0]   div_acac_ff   [DIV_STEPS+1];
   logic [SQ_W-1:0]   div_direct_ff [DIV_STEPS+1];
   region_type        div_region_ff [DIV_STEPS+1];
   logic [ESQ_W-1:0]  esq_in;

   // e^2 = hh<<64 + 2*hl<<32 + ll
   assign esq_in = {hh5_ff, {(2*LO_W){1'b0}}}
                 + {{(LO_W+1){1'b0}}, hl5_ff, {(LO_W+1){1'b0}}}
                 + {{(ESQ_W-2*LO_W){1'b0}}, ll5_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_v_ff[0] <= 1'b0;
      end else if (adv) begin
         div_v_ff[0] <= v5_ff;
      end
      if (adv) begin
         // the upper half is below f whenever e < f, so the quotient fits
         div_rem_ff[0]    <= esq_in[ESQ_W-1:SQ_W];
         div_num_ff[0]    <= esq_in[SQ_W-1:0];
         div_quo_ff[0]    <= '0;
         div_f_ff[0]      <= f5_ff;
         div_acac_ff[0]   <= acac5_ff;
         div_direct_ff[0] <= direct5_ff;
         div_region_ff[0] <= region5_ff;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [SQ_W:0]   shifted;
      logic [SQ_W+1:0] trial;

      // restoring step: bring down one numerator bit, subtract if it fits
      assign shifted = {div_rem_ff[k], div_num_ff[k][SQ_W-1]};
      assign trial   = {1'b0, shifted} - {2'b00, div_f_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            div_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            div_v_ff[k+1] <= div_v_ff[k];
         end
         if (adv) begin
            div_rem_ff[k+1]    <= trial[SQ_W+1] ? shifted[SQ_W-1:0] : trial[SQ_W-1:0];
            div_num_ff[k+1]    <= {div_num_ff[k][SQ_W-2:0], 1'b0};
            div_quo_ff[k+1]    <= {div_quo_ff[k][SQ_W-2:0], ~trial[SQ_W+1]};
            div_f_ff[k+1]      <= div_f_ff[k];
            div_acac_ff[k+1]   <= div_acac_ff[k];
            div_direct_ff[k+1] <= div_direct_ff[k];
            div_region_ff[k+1] <= div_region_ff[k];
         end
      end
   end

   // ---------------- radicand select, then root pipeline
   logic              sq_v_ff      [SQRT_STEPS+1];
   logic [SQ_W-1:0]   sq_rem_ff    [SQRT_STEPS+1];
   logic [DIST_W-1:0] sq_res_ff    [SQRT_STEPS+1];
   region_type        sq_region_ff [SQRT_STEPS+1];
   logic [SQ_W:0]     rad_diff;
   logic [SQ_W-1:0]   rad_in;

   // interior: acac - quotient, clamped at zero
   assign rad_diff = {1'b0, div_acac_ff[DIV_STEPS]} - {1'b0, div_quo_ff[DIV_STEPS]};

   always_comb begin
      if (div_region_ff[DIV_STEPS] != REGION_INTERIOR) begin
         rad_in = div_direct_ff[DIV_STEPS];
      end else if (rad_diff[SQ_W]) begin
         rad_in = '0;
      end else begin
         rad_in = rad_diff[SQ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= div_v_ff[DIV_STEPS];
      end
      if (adv) begin
         sq_rem_ff[0]    <= rad_in;
         sq_res_ff[0]    <= '0;
         sq_region_ff[0] <= div_region_ff[DIV_STEPS];
      end
   end

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      localparam int B = SQRT_STEPS - 1 - j;
      logic [SQ_W+1:0] step;
      logic [SQ_W+1:0] trial;

      // (res + 2^B)^2 - res^2 = res*2^(B+1) + 2^(2B)
      assign step  = ((SQ_W+2)'(sq_res_ff[j]) << (B + 1)) + ((SQ_W+2)'(1) << (2 * B));
      assign trial = {2'b00, sq_rem_ff[j]} - step;

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[j+1] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[j+1] <= sq_v_ff[j];
         end
         if (adv) begin
            sq_rem_ff[j+1]    <= trial[SQ_W+1] ? sq_rem_ff[j] : trial[SQ_W-1:0];
            sq_res_ff[j+1]    <= sq_res_ff[j] | (trial[SQ_W+1] ? '0 : DIST_W'(1) << B);
            sq_region_ff[j+1] <= sq_region_ff[j];
         end
      end
   end

   // last root stage is the output register
   assign rsp_valid          = sq_v_ff[SQRT_STEPS];
   assign rsp_distance       = sq_res_ff[SQRT_STEPS];
   assign rsp_nearest_region = sq_region_ff[SQRT_STEPS];

   // ---------------- assertions
   `PSD_ASSERT_NEXT(a_stall_freezes, stall, $stable(v3_ff) && $stable(div_v_ff[DIV_STEPS/2]) && $stable(sq_v_ff[SQRT_STEPS/2]))
   `PSD_ASSERT_NOW(a_quotient_bounded, div_v_ff[DIV_STEPS] && (div_region_ff[DIV_STEPS] == REGION_INTERIOR), div_quo_ff[DIV_STEPS] <= div_acac_ff[DIV_STEPS])
   `PSD_ASSERT_NOW(a_root_remainder, rsp_valid, sq_rem_ff[SQRT_STEPS] <= {sq_res_ff[SQRT_STEPS], 1'b0})

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the point-to-segment distance pipeline.
module tb_top;
   import psd_pkg::*;

   localparam int LATENCY     = 106;
   localparam int N_RANDOM    = 1250;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [31:0] ax, ay, az, bx, by, bz, cx, cy, cz;
   } seg_query_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      region_type        region;
   } dist_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_start_x = '0, req_start_y = '0, req_start_z = '0;
   logic signed [31:0] req_end_x = '0, req_end_y = '0, req_end_z = '0;
   logic signed [31:0] req_query_x = '0, req_query_y = '0, req_query_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [DIST_W-1:0] rsp_distance;
   logic [1:0] rsp_nearest_region;

   seg_query_type   pending_items[$];
   dist_result_type expected_dists[$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  checked_count = 0;
   int  region_hits[3] = '{0, 0, 0};
   bit  calm = 1'b0;   // stretch with no idling on either side

   point_segment_distance uut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // floor square root of a nonnegative 140-bit value
   function automatic logic [DIST_W-1:0] floor_root(logic [139:0] x);
      logic [69:0] r;
      logic [69:0] t;
      r = '0;
      for (int b = 34; b >= 0; b--) begin
         t = r | (70'd1 << b);
         if ({70'd0, t} * {70'd0, t} <= x) r = t;
      end
      return r[DIST_W-1:0];
   endfunction

   function automatic dist_result_type predict_distance(seg_query_type q);
      logic signed [139:0] abx, aby, abz, acx, acy, acz, bcx, bcy, bcz;
      logic signed [139:0] e, f, rad;
      dist_result_type r;
      abx = 140'(q.bx) - 140'(q.ax);
      aby = 140'(q.by) - 140'(q.ay);
      abz = 140'(q.bz) - 140'(q.az);
      acx = 140'(q.cx) - 140'(q.ax);
      acy = 140'(q.cy) - 140'(q.ay);
      acz = 140'(q.cz) - 140'(q.az);
      bcx = 140'(q.cx) - 140'(q.bx);
      bcy = 140'(q.cy) - 140'(q.by);
      bcz = 140'(q.cz) - 140'(q.bz);
      e = acx * abx + acy * aby + acz * abz;
      f = abx * abx + aby * aby + abz * abz;
      if (e <= 0) begin
         rad = acx * acx + acy * acy + acz * acz;
         r.region = REGION_START;
      end else if (e >= f) begin
         rad = bcx * bcx + bcy * bcy + bcz * bcz;
         r.region = REGION_END;
      end else begin
         rad = acx * acx + acy * acy + acz * acz - (e * e) / f;
         if (rad < 0) rad = 0;
         r.region = REGION_INTERIOR;
      end
      r.distance = floor_root(rad);
      return r;
   endfunction

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000 + $urandom_range(0, 3);
         1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         2: return $urandom_range(0, 65535) - 32768;
         3: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_item(logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz);
      pending_items.push_back('{ax, ay, az, bx, by, bz, cx, cy, cz});
   endtask

   // directed corners, then random geometry
   initial begin
      logic [31:0] a[3], b[3], c[3];
      int t;
      add_item(0, 0, 0, 0, 0, 0, 0, 0, 0);
      // degenerate segment
      add_item(5, -7, 9, 5, -7, 9, 32'h7FFF_FFFF, 32'h8000_0000, 3);
      add_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      // full span diagonals, query at either far corner
      add_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      add_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      // before start, at start, beyond end, at end, interior
      add_item(0, 0, 0, 32'h10000, 0, 0, -32'h10000, 32'h10000, 0);
      add_item(0, 0, 0, 32'h10000, 0, 0, 0, 32'h30000, 0);
      add_item(0, 0, 0, 32'h10000, 0, 0, 32'h20000, 32'h10000, 0);
      add_item(0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 32'h10000);
      add_item(0, 0, 0, 32'h20000, 0, 0, 32'h10000, 32'h30000, 32'h40000);
      add_item(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
               32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, 0, 0, 0);
      add_item(1, 2, 3, 4, 5, 6, 7, 8, 9);
      for (int n = 0; n < N_RANDOM; n++) begin
         t = $urandom_range(0, 9);
         for (int k = 0; k < 3; k++) begin
            a[k] = pick_coord();
            b[k] = pick_coord();
            c[k] = pick_coord();
            // degenerate segment now and then
            if (t == 0) b[k] = a[k];
            // query near the segment for interior hits
            if (t >= 7) c[k] = a[k] + ($signed(b[k] - a[k]) >>> 1) +
                               $urandom_range(0, 255) - 128;
         end
         add_item(a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2]);
      end
   end

   // reset, then the calm stretch
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == 11) reset <= 1'b0;
      calm <= (cycle_count > 400 && cycle_count < 900);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout, %0d results outstanding", $time, expected_dists.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      seg_query_type q;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_dists.push_back(predict_distance(pending_items.pop_front()));
         end
         if ((!req_valid || req_ready) && pending_items.size() > 0 &&
             (calm || $urandom_range(0, 99) >= 14)) begin
            q = pending_items[0];
            req_valid   <= 1'b1;
            req_start_x <= q.ax; req_start_y <= q.ay; req_start_z <= q.az;
            req_end_x   <= q.bx; req_end_y   <= q.by; req_end_z   <= q.bz;
            req_query_x <= q.cx; req_query_y <= q.cy; req_query_z <= q.cz;
         end else if (!req_valid || req_ready) begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      dist_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_dists.size() == 0) begin
               $display("%0t unexpected result dist=%0d region=%0d", $time,
                        rsp_distance, rsp_nearest_region);
               error_count++;
            end else begin
               want = expected_dists.pop_front();
               checked_count <= checked_count + 1;
               region_hits[want.region] <= region_hits[want.region] + 1;
               if (rsp_distance !== want.distance) begin
                  $display("%0t distance mismatch: expected %0d actual %0d", $time,
                           want.distance, rsp_distance);
                  error_count++;
               end
               if (rsp_nearest_region !== want.region) begin
                  $display("%0t region mismatch: expected %0d actual %0d", $time,
                           want.region, rsp_nearest_region);
                  error_count++;
               end
            end
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= 14);
      end
   end

   // end of run
   initial begin
      @(negedge reset);
      wait (pending_items.size() == 0 && !req_valid);
      wait (expected_dists.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      $display("Checked %0d distances: %0d nearest start, %0d nearest end, %0d interior.",
               checked_count, region_hits[0], region_hits[1], region_hits[2]);
      if (error_count == 0 && expected_dists.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
